// File: hw/rtl/ssn_pkg.sv
// Shared constants, types and a helper function of the swept square noise synth.
package ssn_pkg;

	// Sound length limit and field widths
	localparam int MAX_SAMPLES = 4096;
	localparam int LEN_W       = 13;
	localparam int SAMPLE_W    = 8;
	localparam int PERIOD_W    = 8;
	localparam int STRENGTH_W  = 8;
	localparam int SEED_W      = 16;

	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_SAMPLES);

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_SOUND_LENGTH   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD_START   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD_END     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_NOISE_STRENGTH = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NOISE_SEED     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CRACKLE_ENABLE = 3'd5;

	// Register reset values
	localparam logic [LEN_W-1:0]      RST_SOUND_LENGTH   = 13'd1450;
	localparam logic [PERIOD_W-1:0]   RST_PERIOD_START   = 8'd34;
	localparam logic [PERIOD_W-1:0]   RST_PERIOD_END     = 8'd49;
	localparam logic [STRENGTH_W-1:0] RST_NOISE_STRENGTH = 8'd25;
	localparam logic [SEED_W-1:0]     RST_NOISE_SEED     = 16'd4951;

	// Tone and noise constants
	localparam logic [SEED_W-1:0]   LCG_MUL       = 16'd25173;
	localparam logic [SEED_W-1:0]   LCG_INC       = 16'd13849;
	localparam int                  ENV_PEAK      = 112;
	localparam logic [PERIOD_W-1:0] PERIOD_FLOOR  = 8'd2;
	localparam int                  CRACKLE_ODDS  = 5;
	localparam int                  CRACKLE_AMP   = 70;
	localparam int                  MIDSCALE      = 128;
	localparam int                  NOISE_SHIFT   = 7;
	localparam int                  TONE_GAIN     = 3;
	// Reciprocal of five: x/5 == (x*205)>>10 for all x below 1024
	localparam int                  RECIP5        = 205;
	localparam int                  RECIP5_SHIFT  = 10;

	// Shared divider geometry
	localparam int DIV_NUM_W      = 22;
	localparam int DIV_DEN_W      = 13;
	localparam int DIV_RADIX_BITS = 2;
	localparam int DIV_STEPS      = DIV_NUM_W / DIV_RADIX_BITS;
	localparam int DIV_CNT_W      = $clog2(DIV_STEPS + 1);

	// Controller states
	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_NOISE_MUL,
		S_NOISE_ADD,
		S_NOISE_FADE,
		S_SWEEP_GO,
		S_SWEEP_WAIT,
		S_TONE_GO,
		S_TONE_WAIT,
		S_ENV_GO,
		S_ENV_WAIT,
		S_NOISE_GO,
		S_NOISE_WAIT,
		S_FINISH
	} ssn_state_t;

	// Divider operand selection
	typedef enum logic [1:0] {
		DIV_SWEEP,
		DIV_TONE,
		DIV_ENV,
		DIV_NOISE
	} div_sel_t;

	// Controller to datapath commands
	typedef struct packed {
		logic     load;
		logic     prep;
		logic     noise_mul;
		logic     noise_add;
		logic     noise_fade;
		logic     div_start;
		div_sel_t div_sel;
		logic     set_period;
		logic     set_tone;
		logic     set_env;
		logic     emit;
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic active;
		logic div_busy;
		logic div_done;
		logic out_free;
	} dp_stat_t;

	// One step of the 16-bit linear congruential generator
	function automatic logic [SEED_W-1:0] lcg_iterate(input logic [SEED_W-1:0] x);
		logic [2*SEED_W-1:0] prod;
		prod = (2*SEED_W)'(x) * (2*SEED_W)'(LCG_MUL);
		return prod[SEED_W-1:0] + LCG_INC;
	endfunction

endpackage

// File: hw/rtl/ssn_divider.sv
// Shared unsigned restoring divider, two quotient bits per cycle.
module ssn_divider (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [ssn_pkg::DIV_NUM_W-1:0] num,
	input  logic [ssn_pkg::DIV_DEN_W-1:0] den,
	output logic                          busy,
	output logic                          done,
	output logic [ssn_pkg::DIV_NUM_W-1:0] quo
);
	import ssn_pkg::*;

	logic [DIV_NUM_W-1:0] work_q;
	logic [DIV_DEN_W-1:0] part_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [DIV_NUM_W-1:0] work_nx;
	logic [DIV_DEN_W-1:0] part_nx;

	// Shift in numerator bits and subtract where the partial remainder allows
	always_comb begin
		logic [DIV_DEN_W:0] trial;
		work_nx = work_q;
		part_nx = part_q;
		for (int k = 0; k < DIV_RADIX_BITS; k++) begin
			trial   = {part_nx, work_nx[DIV_NUM_W-1]};
			work_nx = {work_nx[DIV_NUM_W-2:0], 1'b0};
			if (trial >= {1'b0, den_q}) begin
				trial      = trial - {1'b0, den_q};
				work_nx[0] = 1'b1;
			end
			part_nx = trial[DIV_DEN_W-1:0];
		end
	end

	// Sequence the steps; flag completion for one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= DIV_CNT_W'(DIV_STEPS);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Operand and working registers
	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= num;
			part_q <= '0;
			den_q  <= den;
		end else if (busy_q) begin
			work_q <= work_nx;
			part_q <= part_nx;
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = work_q;

endmodule

// File: hw/rtl/ssn_datapath.sv
// Datapath: configuration registers, sound state, noise arithmetic and output register.
module ssn_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write,
	input  logic [ssn_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ssn_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           restart,
	input  ssn_pkg::dp_cmd_t               cmd,
	output ssn_pkg::dp_stat_t              stat,
	input  logic                           out_ready,
	output logic                           out_valid,
	output logic [ssn_pkg::SAMPLE_W-1:0]   sample_value,
	output logic                           final_sample
);
	import ssn_pkg::*;

	// Configuration registers
	logic [LEN_W-1:0]      sound_length_q;
	logic [PERIOD_W-1:0]   half_begin_q;
	logic [PERIOD_W-1:0]   half_final_q;
	logic [STRENGTH_W-1:0] noise_strength_q;
	logic [SEED_W-1:0]     noise_seed_q;
	logic                  crackle_enable_q;

	// Sound state
	logic [LEN_W-1:0]  idx_q;
	logic [SEED_W-1:0] lcg_q;

	// Per-sample working registers
	logic [LEN_W-1:0]        len_q;
	logic [LEN_W-1:0]        rem_q;
	logic [19:0]             sweep_mag_q;
	logic                    sweep_neg_q;
	logic [18:0]             env_num_q;
	logic signed [16:0]      noise_prod_q;
	logic                    hit_q;
	logic signed [9:0]       noise_q;
	logic [DIV_NUM_W-1:0]    fade_mag_q;
	logic                    fade_neg_q;
	logic [PERIOD_W-1:0]     period_q;
	logic                    tone_pos_q;
	logic signed [7:0]       tone_part_q;

	// Output register
	logic                    out_valid_q;
	logic [SAMPLE_W-1:0]     sample_value_q;
	logic                    final_q;

	// Divider connection
	logic [DIV_NUM_W-1:0] div_num;
	logic [DIV_DEN_W-1:0] div_den;
	logic [DIV_NUM_W-1:0] div_quo;
	logic                 div_busy;
	logic                 div_done;

	// Combinational terms
	logic [LEN_W-1:0]      len_now;
	logic [LEN_W-1:0]      rem_now;
	logic                  diff_neg;
	logic [PERIOD_W-1:0]   diff_mag;
	logic [19:0]           sweep_mag;
	logic [18:0]           env_num;
	logic [SEED_W-1:0]     lcg_adv;
	logic signed [16:0]    nraw_x;
	logic signed [16:0]    str_x;
	logic signed [16:0]    nprod;
	logic signed [16:0]    nscaled_w;
	logic signed [9:0]     nscaled;
	logic signed [9:0]     crack;
	logic [8:0]            nmag;
	logic signed [9:0]     psum;
	logic [8:0]            tone3;
	logic [18:0]           tone_recip;
	logic [6:0]            tone_mag;
	logic signed [10:0]    noise_part;
	logic signed [11:0]    tone_ext;
	logic signed [11:0]    noise_ext;
	logic signed [11:0]    value;
	logic [SAMPLE_W-1:0]   value_clamped;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sound_length_q   <= RST_SOUND_LENGTH;
			half_begin_q     <= RST_PERIOD_START;
			half_final_q     <= RST_PERIOD_END;
			noise_strength_q <= RST_NOISE_STRENGTH;
			noise_seed_q     <= RST_NOISE_SEED;
			crackle_enable_q <= 1'b0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_SOUND_LENGTH:   sound_length_q   <= cfg_data[LEN_W-1:0];
				REG_PERIOD_START:   half_begin_q     <= cfg_data[PERIOD_W-1:0];
				REG_PERIOD_END:     half_final_q     <= cfg_data[PERIOD_W-1:0];
				REG_NOISE_STRENGTH: noise_strength_q <= cfg_data[STRENGTH_W-1:0];
				REG_NOISE_SEED:     noise_seed_q     <= cfg_data[SEED_W-1:0];
				REG_CRACKLE_ENABLE: crackle_enable_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Effective length, remaining samples, sweep and envelope products
	assign len_now   = (sound_length_q < MAX_LEN) ? sound_length_q : MAX_LEN;
	assign rem_now   = len_now - idx_q;
	assign diff_neg  = half_final_q < half_begin_q;
	assign diff_mag  = diff_neg ? (half_begin_q - half_final_q)
	                            : (half_final_q - half_begin_q);
	assign sweep_mag = 20'(diff_mag) * 20'(idx_q);
	assign env_num   = 19'(rem_now) * 19'(ENV_PEAK);

	// Noise terms
	assign lcg_adv   = lcg_iterate(lcg_q);
	assign nraw_x    = 17'($signed({~lcg_q[15], lcg_q[14:8]}));
	assign str_x     = $signed({9'b0, noise_strength_q});
	assign nprod     = nraw_x * str_x;
	assign nscaled_w = noise_prod_q[16] ? ((noise_prod_q + 17'sd127) >>> NOISE_SHIFT)
	                                    : (noise_prod_q >>> NOISE_SHIFT);
	assign nscaled   = nscaled_w[9:0];
	assign crack     = !hit_q     ? 10'sd0 :
	                   lcg_adv[0] ? 10'(CRACKLE_AMP) : -10'(CRACKLE_AMP);
	assign nmag      = noise_q[9] ? 9'(-noise_q) : noise_q[8:0];

	// Swept half-period with its floor
	assign psum = sweep_neg_q ? ($signed({2'b0, half_begin_q}) - $signed({2'b0, div_quo[7:0]}))
	                          : ($signed({2'b0, half_begin_q}) + $signed({2'b0, div_quo[7:0]}));

	// Tone share: envelope times three fifths
	assign tone3      = 9'(div_quo[6:0]) * 9'(TONE_GAIN);
	assign tone_recip = 19'(tone3) * 19'(RECIP5);
	assign tone_mag   = tone_recip[RECIP5_SHIFT+6:RECIP5_SHIFT];

	// Sum around midscale and clamp
	assign noise_part = fade_neg_q ? -11'(div_quo[8:0]) : 11'(div_quo[8:0]);
	assign tone_ext   = tone_part_q;
	assign noise_ext  = noise_part;
	assign value      = 12'(MIDSCALE) + tone_ext + noise_ext;
	assign value_clamped = value[11]            ? '0 :
	                       (value > 12'sd255)   ? '1 : value[SAMPLE_W-1:0];

	// Advance sound index and noise generator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= MAX_LEN;
			lcg_q <= '0;
		end else begin
			priority if (cmd.load) begin
				if (restart) begin
					idx_q <= '0;
					lcg_q <= noise_seed_q;
				end
			end else if (cmd.prep) begin
				lcg_q <= lcg_adv;
			end else if (cmd.noise_mul) begin
				if (crackle_enable_q) lcg_q <= lcg_adv;
			end else if (cmd.noise_add) begin
				if (hit_q) lcg_q <= lcg_adv;
			end else if (cmd.emit) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// Working registers of one sample
	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			len_q       <= len_now;
			rem_q       <= rem_now;
			sweep_mag_q <= sweep_mag;
			sweep_neg_q <= diff_neg;
			env_num_q   <= env_num;
		end
		if (cmd.noise_mul) begin
			noise_prod_q <= nprod;
			hit_q        <= crackle_enable_q && (lcg_adv[6:0] < 7'(CRACKLE_ODDS));
		end
		if (cmd.noise_add) begin
			noise_q <= nscaled + crack;
		end
		if (cmd.noise_fade) begin
			fade_mag_q <= DIV_NUM_W'(nmag) * DIV_NUM_W'(rem_q);
			fade_neg_q <= noise_q[9];
		end
		if (cmd.set_period) begin
			period_q <= (psum < $signed({2'b0, PERIOD_FLOOR})) ? PERIOD_FLOOR : psum[7:0];
		end
		if (cmd.set_tone) begin
			tone_pos_q <= div_quo[0];
		end
		if (cmd.set_env) begin
			tone_part_q <= tone_pos_q ? $signed({1'b0, tone_mag}) : -$signed({1'b0, tone_mag});
		end
	end

	// Pick divider operands
	always_comb begin
		unique case (cmd.div_sel)
			DIV_SWEEP: begin
				div_num = DIV_NUM_W'(sweep_mag_q);
				div_den = len_q;
			end
			DIV_TONE: begin
				div_num = DIV_NUM_W'(idx_q);
				div_den = DIV_DEN_W'(period_q);
			end
			DIV_ENV: begin
				div_num = DIV_NUM_W'(env_num_q);
				div_den = len_q;
			end
			DIV_NOISE: begin
				div_num = fade_mag_q;
				div_den = len_q;
			end
			default: begin
				div_num = '0;
				div_den = len_q;
			end
		endcase
	end

	ssn_divider u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.done   (div_done),
		.quo    (div_quo)
	);

	// Hold the result until its transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			sample_value_q <= value_clamped;
			final_q        <= (idx_q + 1'b1) == len_q;
		end
	end

	// Status
	assign stat.active   = (len_now != '0) && (idx_q < len_now);
	assign stat.div_busy = div_busy;
	assign stat.div_done = div_done;
	assign stat.out_free = !out_valid_q || out_ready;

	assign out_valid    = out_valid_q;
	assign sample_value = sample_value_q;
	assign final_sample = final_q;

endmodule

// File: hw/rtl/ssn_controller.sv
// Controller: sequences one sample through noise steps and four divisions.
module ssn_controller (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  ssn_pkg::dp_stat_t stat,
	output ssn_pkg::dp_cmd_t  cmd
);
	import ssn_pkg::*;

	ssn_state_t state_q;
	ssn_state_t state_nx;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE:       if (in_valid) state_nx = S_CHECK;
			S_CHECK:      state_nx = stat.active ? S_NOISE_MUL : S_IDLE;
			S_NOISE_MUL:  state_nx = S_NOISE_ADD;
			S_NOISE_ADD:  state_nx = S_NOISE_FADE;
			S_NOISE_FADE: state_nx = S_SWEEP_GO;
			S_SWEEP_GO:   state_nx = S_SWEEP_WAIT;
			S_SWEEP_WAIT: if (stat.div_done) state_nx = S_TONE_GO;
			S_TONE_GO:    state_nx = S_TONE_WAIT;
			S_TONE_WAIT:  if (stat.div_done) state_nx = S_ENV_GO;
			S_ENV_GO:     state_nx = S_ENV_WAIT;
			S_ENV_WAIT:   if (stat.div_done) state_nx = S_NOISE_GO;
			S_NOISE_GO:   state_nx = S_NOISE_WAIT;
			S_NOISE_WAIT: if (stat.div_done) state_nx = S_FINISH;
			S_FINISH:     if (stat.out_free) state_nx = S_IDLE;
			default:      state_nx = S_IDLE;
		endcase
	end

	// Commands
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			S_CHECK:      cmd.prep       = stat.active;
			S_NOISE_MUL:  cmd.noise_mul  = 1'b1;
			S_NOISE_ADD:  cmd.noise_add  = 1'b1;
			S_NOISE_FADE: cmd.noise_fade = 1'b1;
			S_SWEEP_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_SWEEP;
			end
			S_SWEEP_WAIT: cmd.set_period = stat.div_done;
			S_TONE_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_TONE;
			end
			S_TONE_WAIT:  cmd.set_tone = stat.div_done;
			S_ENV_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_ENV;
			end
			S_ENV_WAIT:   cmd.set_env = stat.div_done;
			S_NOISE_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_NOISE;
			end
			S_NOISE_WAIT: cmd.div_sel = DIV_NOISE;
			S_FINISH: begin
				cmd.div_sel = DIV_NOISE;
				cmd.emit    = stat.out_free;
			end
			default: ;
		endcase
	end

endmodule

// File: hw/rtl/swept_square_noise_synth_unit.sv
// Top level of the swept square-wave synth with LCG noise.
// Each input transfer (restart or not) asks for the next 8-bit sample of the
// sound: a square wave whose half-period sweeps from the start value toward
// the end value, with a linear decay, plus LCG noise and optional crackle, clamped
// around 128. A restart returns to the first sample and reloads the seed. Once
// the sound is finished an input transfer gives no result; the controller goes
// from its check state straight back to idle. A running sample passes through
// the noise steps and four divisions in sequence through one shared divider
// that makes two quotient bits per cycle, then waits for a free output register,
// and only then is the next input taken. The result sits in an output register,
// so the block takes the next input while an earlier result still waits for
// its transfer. Configuration is written through cfg_write, cfg_index and
// cfg_data; the user must do so only while idle, which the block does not enforce.
module swept_square_noise_synth_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write,
	input  logic [ssn_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ssn_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           restart,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [ssn_pkg::SAMPLE_W-1:0]   sample_value,
	output logic                           final_sample
);
	import ssn_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	ssn_controller u_controller (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ssn_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.restart      (restart),
		.cmd          (cmd),
		.stat         (stat),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.sample_value (sample_value),
		.final_sample (final_sample)
	);

`ifndef SYNTHESIS
	// One item at a time: ready drops right after an input transfer
	a_accept_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken again right after a transfer");

	// Never restart the divider while it is still working
	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !stat.div_busy)
		else $error("divider started while busy");

	// A result is loaded only into a free output register
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> stat.out_free)
		else $error("result overwrites a waiting result");

	// A loaded result shows as valid in the next cycle
	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> out_valid)
		else $error("loaded result not presented");
`endif

endmodule
